@@ hdl/pffrr_pkg.sv @@
// Shared types and constants for the per-flow FIFO round-robin core.
package pffrr_pkg;

    localparam int NUM_FLOWS_DEF  = 8;
    localparam int FLOW_DEPTH_DEF = 16;
    localparam int DATA_WIDTH_DEF = 32;

    typedef enum logic [1:0] {
        OP_PUSH  = 2'd0,
        OP_POP   = 2'd1,
        OP_SCOUR = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PUSH,
        S_POP,
        S_READ,
        S_SCOUR,
        S_OUT
    } state_t;

endpackage

@@ hdl/per_flow_fifo_round_robin_core.sv @@
// Per-flow FIFO core with a round-robin service ring. One word in, one word out.
// From accept to the result: a push passes through S_PUSH to S_OUT; a pop
// walks S_POP, skipping stale (empty) flows at the ring head, then goes
// through S_READ to S_OUT if it finds data, or straight to S_OUT if none;
// a scour walks S_SCOUR once per ring entry, then S_OUT. The ring walk is a
// single sequencer step that removes or rotates one ring entry per cycle.
// Input is not ready until the result word has been taken. s_tdata:
// operation[1:0], flow[4:2], push_data[36:5], zero pad. m_tdata: status[1:0],
// pop_data[33:2], pop_flow[36:34], total_count[44:37], zero pad.
module per_flow_fifo_round_robin_core
    import pffrr_pkg::*;
#(
    parameter int NUM_FLOWS  = NUM_FLOWS_DEF,
    parameter int FLOW_DEPTH = FLOW_DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
)(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // operation, flow, push_data
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // status, pop_data, pop_flow, total_count
);
    localparam int FW = (NUM_FLOWS > 1) ? $clog2(NUM_FLOWS) : 1;
    localparam int PW = (FLOW_DEPTH > 1) ? $clog2(FLOW_DEPTH) : 1;
    localparam int CW = $clog2(FLOW_DEPTH + 1);
    localparam int LW = $clog2(NUM_FLOWS + 1);
    localparam int TW = $clog2(NUM_FLOWS * FLOW_DEPTH + 1);
    localparam int AW = FW + PW;

    state_t state_reg, state_next;
    logic [FW-1:0]         flow_reg;
    logic [DATA_WIDTH-1:0] wdata_reg;
    logic [PW-1:0] rp_reg [NUM_FLOWS];
    logic [PW-1:0] wp_reg [NUM_FLOWS];
    logic [CW-1:0] fill_reg [NUM_FLOWS];
    logic [NUM_FLOWS-1:0] inr_reg;
    logic [FW-1:0] ring_reg [NUM_FLOWS];
    logic [FW-1:0] head_reg;
    logic [LW-1:0] len_reg, cnt_reg;
    logic [TW-1:0] total_reg;
    logic [1:0]    st_reg;
    logic [FW-1:0] src_reg;
    logic          rd_reg;

    logic [DATA_WIDTH-1:0] rdata;
    logic                  we;
    logic [AW-1:0]         waddr, raddr;

    // flow index modulo NUM_FLOWS (input flow is 3 bits), as a small table
    logic [2:0]    in_flow;
    logic [FW-1:0] flow_mod;
    assign in_flow = s_tdata[4:2];

    always_comb
    begin
        int m;
        m = 0;
        flow_mod = '0;
        for (int v = 0; v < 8; v++)
        begin
            if (32'(in_flow) == v)
                flow_mod = FW'(m);
            m = (m == NUM_FLOWS - 1) ? 0 : m + 1;
        end
    end

    logic [FW-1:0] hflow, tail_slot, head_inc;
    logic [31:0]   tail_sum;
    assign hflow    = ring_reg[head_reg];
    assign head_inc = (32'(head_reg) == NUM_FLOWS - 1) ? '0 : head_reg + 1'b1;
    // head + length stays below twice NUM_FLOWS, so one subtract wraps it
    assign tail_sum  = 32'(head_reg) + 32'(len_reg);
    assign tail_slot = FW'((tail_sum >= NUM_FLOWS) ? tail_sum - NUM_FLOWS : tail_sum);

    logic [FW-1:0] pflow;
    assign pflow = (state_reg == S_PUSH) ? flow_reg : hflow;
    assign we    = (state_reg == S_PUSH) && (32'(fill_reg[flow_reg]) < FLOW_DEPTH);
    assign waddr = {flow_reg, wp_reg[flow_reg]};
    assign raddr = {hflow, rp_reg[hflow]};

    pffrr_store #(.AW(AW), .DW(DATA_WIDTH)) u_store (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata_reg),
        .raddr(raddr), .rdata(rdata)
    );

    logic [DATA_WIDTH-1:0] data_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (s_tvalid)
                begin
                    case (op_t'(s_tdata[1:0]))
                        OP_PUSH:  state_next = S_PUSH;
                        OP_POP:   state_next = S_POP;
                        OP_SCOUR: state_next = S_SCOUR;
                        default:  state_next = S_OUT;
                    endcase
                end
            S_PUSH:  state_next = S_OUT;
            S_POP:
                if (len_reg == '0)
                    state_next = S_OUT;
                else if (fill_reg[hflow] != '0)
                    state_next = S_READ;
            S_READ:  state_next = S_OUT;
            S_SCOUR:
                if (cnt_reg == '0)
                    state_next = S_OUT;
            S_OUT:
                if (m_tready)
                    state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            inr_reg   <= '0;
            head_reg  <= '0;
            len_reg   <= '0;
            cnt_reg   <= '0;
            total_reg <= '0;
            st_reg    <= ST_DONE;
            src_reg   <= '0;
            rd_reg    <= 1'b0;
            for (int i = 0; i < NUM_FLOWS; i++)
            begin
                rp_reg[i]   <= '0;
                wp_reg[i]   <= '0;
                fill_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                S_IDLE:
                    if (s_tvalid)
                    begin
                        flow_reg  <= flow_mod;
                        wdata_reg <= DATA_WIDTH'(s_tdata[36:5]);
                        st_reg    <= ST_DONE;
                        src_reg   <= '0;
                        rd_reg    <= 1'b0;
                        cnt_reg   <= len_reg;
                    end
                S_PUSH:
                    if (!we)
                        st_reg <= ST_FULL;
                    else
                    begin
                        if (fill_reg[pflow] == '0 && !inr_reg[pflow])
                        begin
                            inr_reg[pflow] <= 1'b1;
                            if (32'(len_reg) < NUM_FLOWS)
                            begin
                                ring_reg[tail_slot] <= pflow;
                                len_reg <= len_reg + 1'b1;
                            end
                        end
                        wp_reg[pflow]   <= (32'(wp_reg[pflow]) == FLOW_DEPTH - 1) ?
                                           '0 : wp_reg[pflow] + 1'b1;
                        fill_reg[pflow] <= fill_reg[pflow] + 1'b1;
                        total_reg       <= total_reg + 1'b1;
                    end
                S_POP:
                    if (len_reg == '0)
                        st_reg <= ST_EMPTY;
                    else if (fill_reg[hflow] != '0)
                    begin
                        // rotate head to tail (length unchanged)
                        ring_reg[tail_slot] <= hflow;
                        head_reg <= head_inc;
                        src_reg  <= hflow;
                        rd_reg   <= 1'b1;
                        rp_reg[hflow]   <= (32'(rp_reg[hflow]) == FLOW_DEPTH - 1) ?
                                           '0 : rp_reg[hflow] + 1'b1;
                        fill_reg[hflow] <= fill_reg[hflow] - 1'b1;
                        total_reg       <= total_reg - 1'b1;
                    end
                    else
                    begin
                        inr_reg[hflow] <= 1'b0;
                        head_reg <= head_inc;
                        len_reg  <= len_reg - 1'b1;
                    end
                S_SCOUR:
                    if (cnt_reg != '0)
                    begin
                        cnt_reg <= cnt_reg - 1'b1;
                        head_reg <= head_inc;
                        if (fill_reg[hflow] != '0)
                            ring_reg[tail_slot] <= hflow;
                        else
                        begin
                            inr_reg[hflow] <= 1'b0;
                            len_reg <= len_reg - 1'b1;
                        end
                    end
                default: ;
            endcase
        end
    end

    // memory read data lands in the cycle after S_POP, in S_READ
    always_ff @(posedge clk)
    begin
        if (state_reg == S_READ)
            data_reg <= rdata;
    end

    logic [31:0] pop_data;
    assign pop_data = rd_reg ? 32'(data_reg) : '0;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_OUT);
    assign m_tdata  = {3'b0, 8'(total_reg), 3'(src_reg), pop_data, st_reg};
endmodule

@@ hdl/pffrr_store.sv @@
// Element memory: one write port, one registered read port.
module pffrr_store
    import pffrr_pkg::*;
#(
    parameter int AW = 7,
    parameter int DW = 32
)(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);
    logic [DW-1:0] mem [0:(1<<AW)-1];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule
